>>> rtl/scrm_pkg.sv
package scrm_pkg;

  // Request opcodes
  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Protocol characters
  localparam logic [7:0] CH_POLL   = 8'h52;  // 'R'
  localparam logic [7:0] CH_LISTEN = 8'h4C;  // 'L'
  localparam logic [7:0] CH_CAPT   = 8'h43;  // 'C'
  localparam logic [7:0] CH_DONE   = 8'h44;  // 'D'
  localparam logic [7:0] CH_OPEN   = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE  = 8'h7D;  // '}'

  // Width of the store position field
  localparam int POS_W = 5;

endpackage

>>> rtl/scrm_ram.sv
module scrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry (old data on a collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/spi_command_response_master_top.sv
// SPI command/response master, one byte-level event per request.
//
// Input channel (in_valid/in_ready): opcode selects receive byte, write
// command entry, start transaction or read response entry; data_byte and
// position carry the byte and the store entry.
// Result channel (out_valid/out_ready): one result per request with the
// byte to transmit, done and overflow flags, captured length, the read
// response byte and the phase after the request.
//
// A request is held in the input register, then its result is loaded into
// the result register. Throughput: one request per cycle while results are
// taken; command and response stores are registered-read RAMs, read ahead.
// When the receiver stalls, the finished result holds in the output
// register and one more request is taken into the input register; then
// in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) returns to idle with pointer, count and
// flags cleared; store contents are left as they are.
module spi_command_response_master_top #(
  parameter int MSG_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_position,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_response_done,
  output logic [5:0] out_response_length,
  output logic [7:0] out_read_byte,
  output logic       out_overflow,
  output logic [2:0] out_phase
);

  import scrm_pkg::*;

  localparam int AW = $clog2(MSG_CAPACITY);
  localparam int CW = $clog2(MSG_CAPACITY + 1);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_POLL    = 3'd1,
    PH_SEND    = 3'd2,
    PH_LISTEN  = 3'd3,
    PH_CAPTURE = 3'd4
  } phase_t;

  // Input register
  logic             in_v_r;
  logic [1:0]       op_r;
  logic [7:0]       data_r;
  logic [POS_W-1:0] pos_r;

  // State
  phase_t        state_r, state_nxt;
  logic [AW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic          done_r, done_nxt;
  logic          ov_r, ov_nxt;

  // Result register
  logic       out_v_r;
  logic       tx_valid_r, tx_valid_nxt;
  logic [7:0] tx_byte_r, tx_byte_nxt;
  logic [7:0] read_byte_r, read_byte_nxt;
  logic       done_out_r;
  logic [5:0] len_out_r;
  logic       ov_out_r;
  logic [2:0] phase_out_r;

  // Store ports
  logic          cmd_we;
  logic [AW-1:0] cmd_waddr;
  logic [7:0]    cmd_rdata;
  logic          cmd_byp_r;
  logic [7:0]    cmd_byp_data_r;
  logic [7:0]    cmd_byte;
  logic          rsp_we;
  logic [AW-1:0] rsp_waddr;
  logic [7:0]    rsp_wdata;
  logic [AW-1:0] rsp_raddr;
  logic [7:0]    rsp_rdata;
  logic          rsp_byp_r;
  logic [7:0]    rsp_byp_data_r;
  logic [7:0]    rsp_byte;

  logic          proc;
  logic          in_acc;
  logic          pos_ok;
  logic [AW:0]   sp_inc;

  // Handshake: process when the result register is free or being emptied
  assign proc     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || proc;
  assign in_acc   = in_valid && in_ready;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_acc) begin
      op_r   <= in_opcode;
      data_r <= in_data_byte;
      pos_r  <= in_position;
    end
  end

  assign pos_ok    = 32'(pos_r) < 32'(MSG_CAPACITY);
  assign cmd_waddr = AW'(pos_r);
  assign sp_inc    = {1'b0, sp_r} + (AW + 1)'(1);

  // Forward a store write that collides with the prefetch read
  assign cmd_byte  = cmd_byp_r ? cmd_byp_data_r : cmd_rdata;
  assign rsp_byte  = rsp_byp_r ? rsp_byp_data_r : rsp_rdata;
  assign rsp_raddr = in_acc ? AW'(in_position) : AW'(pos_r);

  // Next state and result
  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    cc_nxt        = cc_r;
    done_nxt      = done_r;
    ov_nxt        = ov_r;
    tx_valid_nxt  = 1'b0;
    tx_byte_nxt   = 8'd0;
    read_byte_nxt = 8'd0;
    cmd_we        = 1'b0;
    rsp_we        = 1'b0;
    rsp_waddr     = AW'(cc_r);
    rsp_wdata     = data_r;
    if (proc) begin
      unique case (op_r)
        OP_RX: begin
          unique case (state_r)
            PH_POLL: begin
              tx_valid_nxt = 1'b1;
              tx_byte_nxt  = CH_POLL;
              if (data_r == CH_LISTEN) begin
                state_nxt = PH_SEND;
                sp_nxt    = '0;
              end
            end
            PH_SEND: begin
              tx_valid_nxt = 1'b1;
              tx_byte_nxt  = cmd_byte;
              sp_nxt = (sp_inc == (AW + 1)'(MSG_CAPACITY)) ? '0 : sp_inc[AW-1:0];
              if (cmd_byte == CH_CLOSE) begin
                state_nxt = PH_LISTEN;
              end
            end
            PH_LISTEN: begin
              tx_valid_nxt = 1'b1;
              if (data_r == CH_OPEN) begin
                state_nxt   = PH_CAPTURE;
                rsp_we      = 1'b1;
                rsp_waddr   = '0;
                rsp_wdata   = CH_OPEN;
                cc_nxt      = CW'(1);
                tx_byte_nxt = CH_CAPT;
              end else begin
                tx_byte_nxt = CH_LISTEN;
              end
            end
            PH_CAPTURE: begin
              tx_valid_nxt = 1'b1;
              // Store the byte, or drop it once the store is full
              if (cc_r < CW'(MSG_CAPACITY)) begin
                rsp_we = 1'b1;
                cc_nxt = cc_r + 1'b1;
              end else begin
                ov_nxt = 1'b1;
              end
              if (data_r == CH_CLOSE) begin
                state_nxt   = PH_IDLE;
                done_nxt    = 1'b1;
                tx_byte_nxt = CH_DONE;
              end else begin
                tx_byte_nxt = CH_CAPT;
              end
            end
            default: begin
            end
          endcase
        end
        OP_WRITE: begin
          cmd_we = pos_ok;
        end
        OP_START: begin
          state_nxt    = PH_POLL;
          sp_nxt       = '0;
          cc_nxt       = '0;
          done_nxt     = 1'b0;
          ov_nxt       = 1'b0;
          tx_valid_nxt = 1'b1;
          tx_byte_nxt  = CH_POLL;
        end
        OP_READ: begin
          if (pos_ok) begin
            read_byte_nxt = rsp_byte;
          end
        end
      endcase
    end
  end

  // Advance state and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
      sp_r    <= '0;
      cc_r    <= '0;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      cc_r    <= cc_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
      if (proc) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (proc) begin
      tx_valid_r  <= tx_valid_nxt;
      tx_byte_r   <= tx_byte_nxt;
      read_byte_r <= read_byte_nxt;
      done_out_r  <= done_nxt;
      len_out_r   <= 6'(cc_nxt);
      ov_out_r    <= ov_nxt;
      phase_out_r <= state_nxt;
    end
  end

  // Capture collisions between a store write and the prefetch address
  always_ff @(posedge clk) begin
    cmd_byp_r      <= cmd_we && (cmd_waddr == sp_nxt);
    cmd_byp_data_r <= data_r;
    rsp_byp_r      <= rsp_we && (rsp_waddr == rsp_raddr);
    rsp_byp_data_r <= rsp_wdata;
  end

  // Command store: read ahead at the next send pointer
  scrm_ram #(
    .WIDTH (8),
    .DEPTH (MSG_CAPACITY)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (cmd_waddr),
    .wdata (data_r),
    .raddr (sp_nxt),
    .rdata (cmd_rdata)
  );

  // Response store: read at the position of the request being taken in
  scrm_ram #(
    .WIDTH (8),
    .DEPTH (MSG_CAPACITY)
  ) u_rsp_ram (
    .clk   (clk),
    .we    (rsp_we),
    .waddr (rsp_waddr),
    .wdata (rsp_wdata),
    .raddr (rsp_raddr),
    .rdata (rsp_rdata)
  );

  assign out_valid           = out_v_r;
  assign out_tx_valid        = tx_valid_r;
  assign out_tx_byte         = tx_byte_r;
  assign out_read_byte       = read_byte_r;
  assign out_response_done   = done_out_r;
  assign out_response_length = len_out_r;
  assign out_overflow        = ov_out_r;
  assign out_phase           = phase_out_r;

endmodule

>>> sim/spi_command_response_master_top_tb.sv
`timescale 1ns / 1ps

module spi_command_response_master_top_tb;
  import scrm_pkg::*;

  localparam int CAPACITY = 32;
  localparam int ITEMS = 1950;
  localparam int MAX_GAP = 12;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_POLL    = 3'd1,
    PH_SEND    = 3'd2,
    PH_LISTEN  = 3'd3,
    PH_CAPTURE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data;
    logic [4:0] position;
  } spi_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       done;
    logic [5:0] length;
    logic [7:0] read_byte;
    logic       overflow;
    logic [2:0] phase;
  } exchange_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = OP_RX;
  logic [7:0] in_data_byte = 8'h00;
  logic [4:0] in_position = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic       out_response_done;
  logic [5:0] out_response_length;
  logic [7:0] out_read_byte;
  logic       out_overflow;
  logic [2:0] out_phase;

  spi_req_t         pending_reqs[$];
  exchange_result_t expected_results[$];
  int               error_count = 0;

  // Predicted master state
  phase_t     m_phase = PH_IDLE;
  logic [7:0] cmd_mem[CAPACITY];
  logic [7:0] rsp_mem[CAPACITY];
  int         send_ptr = 0;
  int         capt_cnt = 0;
  logic       pred_done = 1'b0;
  logic       pred_ovf = 1'b0;

  // Stimulus bookkeeping: command bytes as written, response entries known filled
  logic [7:0] gen_cmd[CAPACITY];
  int         rsp_known = 0;

  int   send_gap = 0;
  int   rcv_stall = 0;
  logic send_burst = 1'b0;
  logic rcv_burst = 1'b0;

  spi_command_response_master_top #(
    .MSG_CAPACITY(CAPACITY)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_valid       (out_tx_valid),
    .out_tx_byte        (out_tx_byte),
    .out_response_done  (out_response_done),
    .out_response_length(out_response_length),
    .out_read_byte      (out_read_byte),
    .out_overflow       (out_overflow),
    .out_phase          (out_phase)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Store one response byte, or flag overflow once the store is full
  task automatic store_response(input logic [7:0] b);
    if (capt_cnt < CAPACITY) begin
      rsp_mem[capt_cnt] = b;
      capt_cnt++;
    end else begin
      pred_ovf = 1'b1;
    end
  endtask

  // Advance the predicted master by one request and queue its result
  task automatic advance_master(input logic [1:0] op, input logic [7:0] data,
                                input logic [4:0] pos);
    exchange_result_t r;
    logic [7:0] b;
    r = '0;
    case (op)
      OP_RX: begin
        case (m_phase)
          PH_POLL: begin
            if (data == CH_LISTEN) begin
              m_phase = PH_SEND;
              send_ptr = 0;
            end
            r.tx_valid = 1'b1;
            r.tx_byte = CH_POLL;
          end
          PH_SEND: begin
            b = cmd_mem[send_ptr];
            send_ptr = (send_ptr + 1) % CAPACITY;
            if (b == CH_CLOSE) m_phase = PH_LISTEN;
            r.tx_valid = 1'b1;
            r.tx_byte = b;
          end
          PH_LISTEN: begin
            r.tx_valid = 1'b1;
            if (data == CH_OPEN) begin
              m_phase = PH_CAPTURE;
              capt_cnt = 0;
              store_response(CH_OPEN);
              r.tx_byte = CH_CAPT;
            end else begin
              r.tx_byte = CH_LISTEN;
            end
          end
          PH_CAPTURE: begin
            store_response(data);
            r.tx_valid = 1'b1;
            if (data == CH_CLOSE) begin
              m_phase = PH_IDLE;
              pred_done = 1'b1;
              r.tx_byte = CH_DONE;
            end else begin
              r.tx_byte = CH_CAPT;
            end
          end
          default: ;  // idle: drop the byte
        endcase
      end
      OP_WRITE: begin
        if (int'(pos) < CAPACITY) cmd_mem[pos] = data;
      end
      OP_START: begin
        m_phase = PH_POLL;
        send_ptr = 0;
        capt_cnt = 0;
        pred_done = 1'b0;
        pred_ovf = 1'b0;
        r.tx_valid = 1'b1;
        r.tx_byte = CH_POLL;
      end
      default: begin
        if (int'(pos) < CAPACITY) r.read_byte = rsp_mem[pos];
      end
    endcase
    r.done = pred_done;
    r.length = 6'(capt_cnt);
    r.overflow = pred_ovf;
    r.phase = m_phase;
    expected_results.push_back(r);
  endtask

  task automatic push_req(input logic [1:0] op, input logic [7:0] data,
                          input logic [4:0] pos);
    spi_req_t r;
    r.opcode = op;
    r.data = data;
    r.position = pos;
    pending_reqs.push_back(r);
    if (op == OP_WRITE) gen_cmd[pos] = data;
  endtask

  function automatic logic [7:0] rand_except(input logic [7:0] avoid);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == avoid) v = 8'($urandom);
    return v;
  endfunction

  // Queue a received byte, now and then preceded by a read of a filled entry
  task automatic push_rx(input logic [7:0] data);
    if (rsp_known > 0 && $urandom_range(0, 11) == 0)
      push_req(OP_READ, 8'($urandom), 5'($urandom_range(0, rsp_known - 1)));
    push_req(OP_RX, data, 5'($urandom));
  endtask

  // Build the request list
  initial begin
    int first_close;
    int k;
    int n;
    int cut;
    int mode;
    logic [1:0] op;

    // Directed: ignored bytes, extreme fields, a full exchange, reads, aborts
    push_req(OP_RX, 8'hFF, 5'd0);
    push_req(OP_RX, 8'h00, 5'd31);
    push_req(OP_WRITE, 8'h00, 5'd0);
    push_req(OP_WRITE, 8'hFF, 5'd1);
    push_req(OP_WRITE, CH_CLOSE, 5'd2);
    push_req(OP_WRITE, 8'h5A, 5'd31);
    push_req(OP_START, 8'hFF, 5'd31);
    push_req(OP_RX, 8'h00, 5'd0);
    push_req(OP_RX, CH_LISTEN, 5'd0);
    push_req(OP_RX, 8'hFF, 5'd0);
    push_req(OP_RX, 8'h00, 5'd0);
    push_req(OP_RX, 8'h11, 5'd0);
    push_req(OP_RX, 8'hFF, 5'd0);
    push_req(OP_RX, CH_OPEN, 5'd0);
    push_req(OP_RX, 8'h00, 5'd0);
    push_req(OP_RX, 8'hFF, 5'd0);
    push_req(OP_RX, CH_CLOSE, 5'd0);
    push_req(OP_READ, 8'h00, 5'd0);
    push_req(OP_READ, 8'hFF, 5'd3);
    push_req(OP_START, 8'h00, 5'd0);
    push_req(OP_RX, CH_LISTEN, 5'd0);
    push_req(OP_RX, 8'h00, 5'd0);
    push_req(OP_START, 8'h00, 5'd0);
    push_req(OP_READ, 8'h00, 5'd2);
    rsp_known = 4;

    // Fill the whole command store so every send reads a defined entry
    for (int i = 0; i < CAPACITY; i++) push_req(OP_WRITE, 8'($urandom), 5'(i));

    while (pending_reqs.size() < ITEMS) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
        // Command with no closing brace: the send pointer wraps
        for (int i = 0; i < CAPACITY; i++) push_req(OP_WRITE, rand_except(CH_CLOSE), 5'(i));
        push_req(OP_START, 8'($urandom), 5'($urandom));
        push_rx(CH_LISTEN);
        repeat (CAPACITY + $urandom_range(1, 10)) push_rx(8'($urandom));
        if ($urandom_range(0, 1) == 0) push_req(OP_START, 8'($urandom), 5'($urandom));
      end else if (mode <= 3) begin
        // Noise: any request with random content
        repeat ($urandom_range(1, 6)) begin
          op = 2'($urandom);
          if (op == OP_READ && rsp_known == 0) op = OP_RX;
          if (op == OP_READ)
            push_req(op, 8'($urandom), 5'($urandom_range(0, rsp_known - 1)));
          else
            push_req(op, 8'($urandom), 5'($urandom));
        end
      end else begin
        // Well-formed exchange, now and then cut short
        first_close = -1;
        for (int i = CAPACITY - 1; i >= 0; i--)
          if (gen_cmd[i] == CH_CLOSE) first_close = i;
        if (first_close < 0 || $urandom_range(0, 2) == 0) begin
          k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, CAPACITY - 1)
                                          : $urandom_range(0, 5);
          for (int i = 0; i < k; i++) push_req(OP_WRITE, rand_except(CH_CLOSE), 5'(i));
          push_req(OP_WRITE, CH_CLOSE, 5'(k));
          first_close = k;
        end
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
        push_req(OP_START, 8'($urandom), 5'($urandom));
        repeat ($urandom_range(0, 3)) push_rx(rand_except(CH_LISTEN));
        if (cut > 0) begin
          push_rx(CH_LISTEN);
          n = (cut == 1) ? $urandom_range(0, first_close) : first_close + 1;
          repeat (n) push_rx(8'($urandom));
        end
        if (cut > 1) begin
          repeat ($urandom_range(0, 3)) push_rx(rand_except(CH_OPEN));
          push_rx(CH_OPEN);
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(CAPACITY - 3, CAPACITY + 12)
                                          : $urandom_range(0, 10);
          if (cut == 3) n = $urandom_range(0, n);
          repeat (n) push_rx(rand_except(CH_CLOSE));
          if (cut == 4) begin
            push_rx(CH_CLOSE);
            n++;
          end
          if (n + 1 > rsp_known) rsp_known = (n + 1 > CAPACITY) ? CAPACITY : n + 1;
        end
      end
    end
  end

  // Drive requests; hold each one until it is taken
  always @(posedge clk) begin : drive_proc
    spi_req_t req;
    logic hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        advance_master(in_opcode, in_data_byte, in_position);
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          in_opcode <= req.opcode;
          in_data_byte <= req.data;
          in_position <= req.position;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take results with random stalls and check them against the prediction
  always @(posedge clk) begin : watch_proc
    exchange_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error("result with no request pending");
        end else begin
          want = expected_results.pop_front();
          if (out_tx_valid !== want.tx_valid)
            report_error($sformatf("tx_valid %b, expected %b", out_tx_valid, want.tx_valid));
          if (out_tx_byte !== want.tx_byte)
            report_error($sformatf("tx_byte %h, expected %h", out_tx_byte, want.tx_byte));
          if (out_response_done !== want.done)
            report_error($sformatf("response_done %b, expected %b",
                                   out_response_done, want.done));
          if (out_response_length !== want.length)
            report_error($sformatf("response_length %0d, expected %0d",
                                   out_response_length, want.length));
          if (out_read_byte !== want.read_byte)
            report_error($sformatf("read_byte %h, expected %h", out_read_byte, want.read_byte));
          if (out_overflow !== want.overflow)
            report_error($sformatf("overflow %b, expected %b", out_overflow, want.overflow));
          if (out_phase !== want.phase)
            report_error($sformatf("phase %0d, expected %0d", out_phase, want.phase));
        end
        if ($urandom_range(0, 31) == 0) rcv_burst = !rcv_burst;
        rcv_stall = rcv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else if (rcv_stall > 0) begin
        rcv_stall--;
      end
      out_ready <= (rcv_stall == 0);
    end
  end

  // Wait for the last result, let the block settle, then give the verdict
  initial begin
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_error("expected result never arrived");
    if (error_count == 0) begin
      $display("spi_command_response_master_top test passed");
    end else begin
      $display("spi_command_response_master_top test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("spi_command_response_master_top test failed");
    $finish;
  end

endmodule
